// File: design/taa_pkg.sv
// ----------------------------------------------------------------------------
// taa_pkg: shared types and constants for the trusted address allowlist
// Command codes, sequencer states, register indexes and item/result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package taa_pkg;

    localparam int ADDR_W    = 48;
    localparam int TIME_W    = 32;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [TIME_W-1:0] GRACE_RESET = 32'd60000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_CONNECT = 3'd2,
        CMD_LOOKUP  = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOOT_TIME    = 1'd0,
        CFG_GRACE_WINDOW = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_APPEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              which_list;
        logic [ADDR_W-1:0] device_addr;
        logic              addr_present;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic               allowed;
        logic               changed;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

`default_nettype wire

// File: design/taa_in_if.sv
// ----------------------------------------------------------------------------
// taa_in_if: request channel of the trusted address allowlist
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface taa_in_if;
    logic                       valid;
    logic                       ready;
    logic [taa_pkg::CMD_W-1:0]  command;
    logic                       which_list;
    logic [taa_pkg::ADDR_W-1:0] device_addr;
    logic                       addr_present;
    logic [taa_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, command, which_list, device_addr, addr_present, now_ms,
                    input ready);
    modport sink   (input valid, command, which_list, device_addr, addr_present, now_ms,
                    output ready);
endinterface

`default_nettype wire

// File: design/taa_out_if.sv
// ----------------------------------------------------------------------------
// taa_out_if: result channel of the trusted address allowlist
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface taa_out_if;
    logic                        valid;
    logic                        ready;
    logic                        allowed;
    logic                        changed;
    logic [taa_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, allowed, changed, entry_count, input ready);
    modport sink   (input valid, allowed, changed, entry_count, output ready);
endinterface

`default_nettype wire

// File: design/taa_mem.sv
// ----------------------------------------------------------------------------
// taa_mem: entry storage for both lists
// One write port and one registered read port; list select is the top address bit.
// ----------------------------------------------------------------------------
`default_nettype none

module taa_mem #(
    parameter int AW = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [taa_pkg::ADDR_W-1:0] i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [taa_pkg::ADDR_W-1:0] o_rdata
);

    logic [taa_pkg::ADDR_W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/taa_seq.sv
// ----------------------------------------------------------------------------
// taa_seq: command sequencer of the trusted address allowlist
// Scans entries through one comparator, shifts entries down to close gaps,
// appends new entries and keeps both fill counts.
// ----------------------------------------------------------------------------
`default_nettype none

module taa_seq #(
    parameter int LIST_DEPTH = 12,
    parameter int IW         = 4,
    parameter int CW         = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire taa_pkg::t_item             i_item,
    input  wire logic [taa_pkg::TIME_W-1:0] i_boot_time,
    input  wire logic [taa_pkg::TIME_W-1:0] i_grace_window,
    output logic                            o_done,
    output taa_pkg::t_result                o_res,
    input  wire logic                       i_take,
    output logic                            o_mem_we,
    output logic      [IW:0]                o_mem_waddr,
    output logic      [taa_pkg::ADDR_W-1:0] o_mem_wdata,
    output logic      [IW:0]                o_mem_raddr,
    input  wire logic [taa_pkg::ADDR_W-1:0] i_mem_rdata
);

    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    taa_pkg::t_state            r_state, n_state;
    taa_pkg::t_cmd              r_cmd, n_cmd;
    logic                       r_sel, n_sel;
    logic [taa_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                       r_grace, n_grace;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_pidx, n_pidx;
    logic                       r_rv, n_rv;
    logic                       r_allowed, n_allowed;
    logic                       r_changed, n_changed;
    logic [CW-1:0]              r_cnt [2];
    logic [CW-1:0]              n_cnt [2];

    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] in_cnt;
    logic [CW-1:0] w_idx;
    logic          hit;
    logic          admit;
    logic          now_grace;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= taa_pkg::S_IDLE;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_rv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt[0] <= n_cnt[0];
            r_cnt[1] <= n_cnt[1];
            r_rv <= n_rv;
        end
        r_cmd <= n_cmd;
        r_sel <= n_sel;
        r_addr <= n_addr;
        r_grace <= n_grace;
        r_idx <= n_idx;
        r_pidx <= n_pidx;
        r_allowed <= n_allowed;
        r_changed <= n_changed;
    end

    assign cur_cnt   = r_cnt[r_sel];
    assign in_cnt    = r_cnt[i_item.which_list];
    assign now_grace = (i_item.now_ms - i_boot_time) < i_grace_window;
    assign hit       = r_rv && (i_mem_rdata == r_addr);
    assign admit     = (r_cmd == taa_pkg::CMD_ADD) || r_grace || hit;

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_sel = r_sel;
        n_addr = r_addr;
        n_grace = r_grace;
        n_idx = r_idx;
        n_pidx = r_pidx;
        n_rv = r_rv;
        n_allowed = r_allowed;
        n_changed = r_changed;
        n_cnt[0] = r_cnt[0];
        n_cnt[1] = r_cnt[1];
        o_ready = 1'b0;
        o_done = 1'b0;
        o_mem_we = 1'b0;
        w_idx = r_pidx - ONE_C;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = {r_sel, r_idx[IW-1:0]};

        case (r_state)
            taa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd = taa_pkg::t_cmd'(i_item.command);
                    n_sel = i_item.which_list;
                    n_addr = i_item.device_addr;
                    n_grace = now_grace;
                    n_idx = '0;
                    n_rv = 1'b0;
                    n_allowed = 1'b0;
                    n_changed = 1'b0;
                    n_state = taa_pkg::S_DONE;
                    case (taa_pkg::t_cmd'(i_item.command))
                        taa_pkg::CMD_CLEAR: begin
                            n_changed = in_cnt != '0;
                            n_cnt[i_item.which_list] = '0;
                        end
                        taa_pkg::CMD_ADD, taa_pkg::CMD_REMOVE, taa_pkg::CMD_LOOKUP: begin
                            if (i_item.addr_present) begin
                                n_state = taa_pkg::S_SEARCH;
                            end
                        end
                        taa_pkg::CMD_CONNECT: begin
                            if (i_item.addr_present) begin
                                n_state = taa_pkg::S_SEARCH;
                            end else begin
                                n_allowed = i_item.which_list ? now_grace : 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            taa_pkg::S_SEARCH: begin
                if (hit || (!r_rv && r_idx >= cur_cnt)) begin
                    n_rv = 1'b0;
                    n_state = taa_pkg::S_DONE;
                    case (r_cmd)
                        taa_pkg::CMD_LOOKUP: begin
                            n_allowed = hit;
                        end
                        taa_pkg::CMD_REMOVE: begin
                            if (hit) begin
                                n_changed = 1'b1;
                                n_idx = r_pidx + ONE_C;
                                n_state = taa_pkg::S_SHIFT;
                            end
                        end
                        taa_pkg::CMD_ADD, taa_pkg::CMD_CONNECT: begin
                            n_allowed = (r_cmd == taa_pkg::CMD_CONNECT) && admit;
                            if (admit && !hit) begin
                                n_changed = 1'b1;
                                if (cur_cnt >= DEPTH_C) begin
                                    n_idx = ONE_C;
                                    n_state = taa_pkg::S_SHIFT;
                                end else begin
                                    n_state = taa_pkg::S_APPEND;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_idx < cur_cnt) begin
                    n_rv = 1'b1;
                    n_pidx = r_idx;
                    n_idx = r_idx + ONE_C;
                end else begin
                    n_rv = 1'b0;
                end
            end
            taa_pkg::S_SHIFT: begin
                // read entry k, write it to k-1 in the next cycle
                o_mem_we = r_rv;
                if (r_idx < cur_cnt) begin
                    n_rv = 1'b1;
                    n_pidx = r_idx;
                    n_idx = r_idx + ONE_C;
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_cnt[r_sel] = cur_cnt - ONE_C;
                        n_state = (r_cmd == taa_pkg::CMD_REMOVE) ? taa_pkg::S_DONE
                                                                 : taa_pkg::S_APPEND;
                    end
                end
            end
            taa_pkg::S_APPEND: begin
                o_mem_we = 1'b1;
                w_idx = cur_cnt;
                o_mem_wdata = r_addr;
                n_cnt[r_sel] = cur_cnt + ONE_C;
                n_state = taa_pkg::S_DONE;
            end
            taa_pkg::S_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = taa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = taa_pkg::S_IDLE;
            end
        endcase

        o_mem_waddr = {r_sel, w_idx[IW-1:0]};
    end

    assign o_res.allowed     = r_allowed;
    assign o_res.changed     = r_changed;
    assign o_res.entry_count = taa_pkg::COUNT_W'(cur_cnt);

endmodule

`default_nettype wire

// File: design/trusted_address_allowlist_core.sv
// ----------------------------------------------------------------------------
// trusted_address_allowlist_core: two trusted device address lists
// Commands arrive on i_in (add, remove, connect check, lookup, clear) and each
// transfer yields exactly one result transfer on o_out.
// Configuration: i_cfg_we writes i_cfg_data to boot_time (index 0) or
// grace_window (index 1); write only while no command is in flight.
// Flow: clear, absent address and unused codes go straight from idle to the
// done state and the output register. Commands with an address scan the
// selected list through one comparator, one entry per cycle; remove and add
// or connect with eviction then shift the tail down one entry per cycle,
// and an admitted add or connect then appends the new entry.
// Throughput: one command at a time; i_in.ready is high only while the
// sequencer is idle. The output register holds a result while o_out stalls,
// and the next command can be taken and processed meanwhile; its result then
// waits in the sequencer until the output register frees.
// Reset: both lists empty, boot_time 0, grace_window 60000, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module trusted_address_allowlist_core #(
    parameter int LIST_DEPTH = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    taa_in_if.sink                             i_in,
    taa_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [taa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [taa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [taa_pkg::TIME_W-1:0] r_boot_time;
    logic [taa_pkg::TIME_W-1:0] r_grace_window;
    logic                       r_out_valid;
    taa_pkg::t_result           r_out;

    taa_pkg::t_item             item;
    taa_pkg::t_result           seq_res;
    logic                       seq_done;
    logic                       take;
    logic                       mem_we;
    logic [IW:0]                mem_waddr;
    logic [IW:0]                mem_raddr;
    logic [taa_pkg::ADDR_W-1:0] mem_wdata;
    logic [taa_pkg::ADDR_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_time <= '0;
            r_grace_window <= taa_pkg::GRACE_RESET;
        end else if (i_cfg_we) begin
            case (taa_pkg::t_cfg_idx'(i_cfg_idx))
                taa_pkg::CFG_BOOT_TIME:    r_boot_time <= i_cfg_data;
                taa_pkg::CFG_GRACE_WINDOW: r_grace_window <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign item.command      = i_in.command;
    assign item.which_list   = i_in.which_list;
    assign item.device_addr  = i_in.device_addr;
    assign item.addr_present = i_in.addr_present;
    assign item.now_ms       = i_in.now_ms;

    assign take = !r_out_valid || o_out.ready;

    taa_seq #(
        .LIST_DEPTH (LIST_DEPTH),
        .IW         (IW),
        .CW         (CW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_item         (item),
        .i_boot_time    (r_boot_time),
        .i_grace_window (r_grace_window),
        .o_done         (seq_done),
        .o_res          (seq_res),
        .i_take         (take),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    taa_mem #(
        .AW (IW + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (seq_done && take) begin
            r_out <= seq_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.allowed     = r_out.allowed;
    assign o_out.changed     = r_out.changed;
    assign o_out.entry_count = r_out.entry_count;

endmodule

`default_nettype wire

// File: tb/tb_trusted_address_allowlist_core.sv
// ----------------------------------------------------------------------------
// tb_trusted_address_allowlist_core: self-checking bench for the allowlist core
// Drives command transfers through the request channel with random idle and
// stall bursts and keeps its own copy of both address lists and the grace
// registers. Each result transfer is checked field by field against the
// oldest predicted verdict. The run opens with hand-picked corner commands,
// then walks several register settings with random traffic over a small
// address pool so that the lists fill up, evict and drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trusted_address_allowlist_core;

    localparam int LIST_DEPTH     = 12;
    localparam int POOL_SIZE      = 20;
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASES         = 6;
    localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 16;
    localparam logic [taa_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [taa_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    class allowlist_scoreboard;
        logic [taa_pkg::ADDR_W-1:0] roster [2][LIST_DEPTH];
        int unsigned                roster_len [2];
        logic [taa_pkg::TIME_W-1:0] boot_ms;
        logic [taa_pkg::TIME_W-1:0] grace_ms;
        taa_pkg::t_result           pending_verdicts [$];
        int unsigned                faults;
        int unsigned                requests;
        int unsigned                verdicts_seen;
        int unsigned                evictions;
        int unsigned                admits;

        function new();
            roster_len[0] = 0;
            roster_len[1] = 0;
            boot_ms       = '0;
            grace_ms      = taa_pkg::GRACE_RESET;
            faults        = 0;
            requests      = 0;
            verdicts_seen = 0;
            evictions     = 0;
            admits        = 0;
        endfunction

        function void set_register(taa_pkg::t_cfg_idx idx, logic [taa_pkg::CFG_W-1:0] val);
            case (idx)
                taa_pkg::CFG_BOOT_TIME:    boot_ms  = val;
                taa_pkg::CFG_GRACE_WINDOW: grace_ms = val;
                default: ;
            endcase
        endfunction

        function int find_slot(int lst, logic [taa_pkg::ADDR_W-1:0] addr);
            for (int i = 0; i < int'(roster_len[lst]); i++)
                if (roster[lst][i] == addr)
                    return i;
            return -1;
        endfunction

        function void drop_slot(int lst, int pos);
            for (int i = pos; i + 1 < int'(roster_len[lst]); i++)
                roster[lst][i] = roster[lst][i + 1];
            if (roster_len[lst] > 0)
                roster_len[lst]--;
        endfunction

        function bit insert_addr(int lst, logic [taa_pkg::ADDR_W-1:0] addr);
            if (find_slot(lst, addr) >= 0)
                return 1'b0;
            if (roster_len[lst] >= LIST_DEPTH) begin
                drop_slot(lst, 0);
                evictions++;
            end
            roster[lst][roster_len[lst]] = addr;
            roster_len[lst]++;
            return 1'b1;
        endfunction

        function int unsigned outstanding();
            return pending_verdicts.size();
        endfunction

        function void note_request(taa_pkg::t_item req);
            int                         lst;
            int                         pos;
            logic [taa_pkg::TIME_W-1:0] elapsed;
            bit                         in_grace;
            bit                         ok;
            bit                         modified;
            taa_pkg::t_result           verdict;
            lst      = int'(req.which_list);
            elapsed  = req.now_ms - boot_ms;
            in_grace = elapsed < grace_ms;
            ok       = 1'b0;
            modified = 1'b0;
            case (req.command)
                taa_pkg::CMD_ADD: begin
                    if (req.addr_present)
                        modified = insert_addr(lst, req.device_addr);
                end
                taa_pkg::CMD_REMOVE: begin
                    if (req.addr_present) begin
                        pos = find_slot(lst, req.device_addr);
                        if (pos >= 0) begin
                            drop_slot(lst, pos);
                            modified = 1'b1;
                        end
                    end
                end
                taa_pkg::CMD_CONNECT: begin
                    if (!req.addr_present) begin
                        ok = (lst != 0) ? in_grace : 1'b1;
                    end else begin
                        ok = in_grace || (find_slot(lst, req.device_addr) >= 0);
                        if (ok)
                            modified = insert_addr(lst, req.device_addr);
                    end
                    if (ok)
                        admits++;
                end
                taa_pkg::CMD_LOOKUP: begin
                    ok = req.addr_present && (find_slot(lst, req.device_addr) >= 0);
                end
                taa_pkg::CMD_CLEAR: begin
                    modified        = roster_len[lst] != 0;
                    roster_len[lst] = 0;
                end
                default: ;
            endcase
            verdict.allowed     = ok;
            verdict.changed     = modified;
            verdict.entry_count = roster_len[lst][taa_pkg::COUNT_W-1:0];
            pending_verdicts.insert(pending_verdicts.size(), verdict);
            requests++;
        endfunction

        function void check_verdict(taa_pkg::t_result got);
            taa_pkg::t_result want;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                $error("result transfer with none pending: allowed=%0d changed=%0d count=%0d",
                       got.allowed, got.changed, got.entry_count);
                faults++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.allowed !== want.allowed) begin
                $error("allowed: expected %0d, actual %0d", want.allowed, got.allowed);
                faults++;
            end
            if (got.changed !== want.changed) begin
                $error("changed: expected %0d, actual %0d", want.changed, got.changed);
                faults++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", want.entry_count,
                       got.entry_count);
                faults++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [taa_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [taa_pkg::CFG_W-1:0]     i_cfg_data;
    bit                            allow_idle;
    int unsigned                   settings_used;
    logic [taa_pkg::ADDR_W-1:0]    addr_pool [POOL_SIZE];

    allowlist_scoreboard sb = new();

    taa_in_if  in_ch ();
    taa_out_if out_ch ();

    trusted_address_allowlist_core #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stall bursts on ready
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (allow_idle && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_verdict(taa_pkg::t_result'({out_ch.allowed, out_ch.changed,
                                                 out_ch.entry_count}));
    end

    function automatic taa_pkg::t_item make_item(logic [taa_pkg::CMD_W-1:0] cmd, logic lst,
                                                 logic [taa_pkg::ADDR_W-1:0] addr,
                                                 logic present,
                                                 logic [taa_pkg::TIME_W-1:0] now);
        taa_pkg::t_item req;
        req.command      = cmd;
        req.which_list   = lst;
        req.device_addr  = addr;
        req.addr_present = present;
        req.now_ms       = now;
        return req;
    endfunction

    function automatic logic [taa_pkg::TIME_W-1:0] pick_now();
        case ($urandom_range(0, 5))
            0:       return sb.boot_ms + sb.grace_ms - 1;
            1:       return sb.boot_ms + sb.grace_ms;
            2:       return sb.boot_ms + $urandom_range(0, 2000);
            3:       return sb.boot_ms - 1 - $urandom_range(0, 100);
            default: return $urandom();
        endcase
    endfunction

    function automatic taa_pkg::t_item random_item();
        int unsigned                r;
        logic [taa_pkg::CMD_W-1:0]  cmd;
        logic [taa_pkg::ADDR_W-1:0] addr;
        r = $urandom_range(0, 99);
        if (r < 32)
            cmd = taa_pkg::CMD_ADD;
        else if (r < 47)
            cmd = taa_pkg::CMD_REMOVE;
        else if (r < 72)
            cmd = taa_pkg::CMD_CONNECT;
        else if (r < 94)
            cmd = taa_pkg::CMD_LOOKUP;
        else if (r < 97)
            cmd = taa_pkg::CMD_CLEAR;
        else
            cmd = taa_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        if ($urandom_range(0, 7) == 0)
            addr = taa_pkg::ADDR_W'({$urandom(), $urandom()});
        else
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return make_item(cmd, 1'($urandom_range(0, 1)), addr,
                         $urandom_range(0, 9) != 0, pick_now());
    endfunction

    task automatic drive_item(input taa_pkg::t_item req);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= req.command;
        in_ch.which_list   <= req.which_list;
        in_ch.device_addr  <= req.device_addr;
        in_ch.addr_present <= req.addr_present;
        in_ch.now_ms       <= req.now_ms;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input taa_pkg::t_cfg_idx idx,
                                  input logic [taa_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, val);
        @(posedge i_clk);
    endtask

    initial begin
        logic [taa_pkg::TIME_W-1:0] boot_val;
        logic [taa_pkg::TIME_W-1:0] grace_val;
        logic [taa_pkg::TIME_W-1:0] late;
        late               = 32'd100000;
        allow_idle         = 1'b1;
        settings_used      = 1;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= taa_pkg::CFG_BOOT_TIME;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= taa_pkg::CMD_ADD;
        in_ch.which_list   <= 1'b0;
        in_ch.device_addr  <= '0;
        in_ch.addr_present <= 1'b0;
        in_ch.now_ms       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner commands under the reset grace settings
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b0, '0, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b1, '0, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b1, '0, 1'b0, 32'd59999));
        drive_item(make_item(taa_pkg::CMD_ADD, 1'b0, '1, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_ADD, 1'b0, '0, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_ADD, 1'b0, '1, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_ADD, 1'b0, '0, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_LOOKUP, 1'b0, '0, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_LOOKUP, 1'b0, '0, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_REMOVE, 1'b0, '0, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_REMOVE, 1'b0, 48'h1, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_REMOVE, 1'b0, '0, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b0, '1, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b0, 48'h5555_5555_5555, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b1, 48'hAAAA_AAAA_AAAA, 1'b1,
                             32'd59999));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b1, 48'h5555_5555_5555, 1'b1,
                             32'd60000));
        drive_item(make_item(taa_pkg::CMD_CONNECT, 1'b1, 48'h5555_5555_5555, 1'b1, '1));
        drive_item(make_item(taa_pkg::CMD_LOOKUP, 1'b1, 48'hAAAA_AAAA_AAAA, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_CLEAR, 1'b1, '0, 1'b0, late));
        drive_item(make_item(taa_pkg::CMD_CLEAR, 1'b1, '0, 1'b0, late));
        drive_item(make_item(CMD_UNUSED_LO, 1'b0, '1, 1'b1, late));
        drive_item(make_item(CMD_UNUSED_HI, 1'b1, '1, 1'b1, late));
        drive_item(make_item(taa_pkg::CMD_LOOKUP, 1'b1, 48'hAAAA_AAAA_AAAA, 1'b1, late));
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin boot_val = '0;           grace_val = taa_pkg::GRACE_RESET; end
                1: begin boot_val = $urandom();   grace_val = $urandom_range(1, 100000); end
                2: begin boot_val = $urandom();   grace_val = '0; end
                3: begin boot_val = 32'hFFFF_FF00; grace_val = '1; end
                4: begin boot_val = '1;           grace_val = 32'h0000_1000; end
                default: begin boot_val = $urandom(); grace_val = taa_pkg::GRACE_RESET; end
            endcase
            write_register(taa_pkg::CFG_BOOT_TIME, boot_val);
            write_register(taa_pkg::CFG_GRACE_WINDOW, grace_val);
            settings_used++;
            addr_pool[0] = '0;
            addr_pool[1] = '1;
            for (int i = 2; i < POOL_SIZE; i++)
                addr_pool[i] = taa_pkg::ADDR_W'({$urandom(), $urandom()});
            allow_idle = (ph != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_item(random_item());
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d requests over %0d register settings.",
                 sb.verdicts_seen, sb.requests, settings_used);
        $display("Model saw %0d evictions and %0d admitted connects.",
                 sb.evictions, sb.admits);
        if (sb.faults == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
